// ===== rtl/indexed_min_heap_timer_queue_top_macros.svh =====
// Assertion macros for the indexed min-heap timer queue.
// Used by the top level; no other dependencies.
`ifndef INDEXED_MIN_HEAP_TIMER_QUEUE_TOP_MACROS_SVH
`define INDEXED_MIN_HEAP_TIMER_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define IMHTQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("imhtq assertion failed");
`define IMHTQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("imhtq assertion failed");
`else
`define IMHTQ_ASSERT(lbl, prop)
`define IMHTQ_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/imhtq_pkg.sv =====
// Package for the indexed min-heap timer queue: command and status codes,
// sequencer states, payload structs and default sizes. No dependencies.
package imhtq_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int TIME_BITS_DEF = 32;
    localparam int ID_COUNT      = 256;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_UPDATE = 3'd1,
        CMD_POP    = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_PEEK   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_ID_ERR = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MAP_WAIT,
        S_LOAD_USE,
        S_POP_USE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_PLACE,
        S_HEAD_RD,
        S_HEAD_USE
    } state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  conn_id;
        logic [31:0] time_value;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        head_valid;
        logic [7:0]  head_id;
        logic [31:0] head_time;
        logic [8:0]  occupancy;
    } out_t;

endpackage

// ===== rtl/indexed_min_heap_timer_queue_top.sv =====
// Indexed min-heap timer queue: heap memory, position map memory and sequencer.
// Depends on imhtq_pkg and indexed_min_heap_timer_queue_top_macros.svh.
// Commands are handled one at a time; sift-up and sift-down move one level at a time, paced
// by the single read port of the heap memory. A new transfer is taken in the cycle after the
// result is loaded. Reset clears the id valid flags and the entry count.
`include "indexed_min_heap_timer_queue_top_macros.svh"
module indexed_min_heap_timer_queue_top #(
    parameter int CAPACITY  = imhtq_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = imhtq_pkg::TIME_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  imhtq_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output imhtq_pkg::out_t m_data
);
    import imhtq_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = SW + 2;
    localparam int EW = TIME_BITS + 8;

    logic [EW-1:0] heap_mem [CAPACITY];
    logic [SW-1:0] map_mem  [ID_COUNT];

    state_t state_reg, state_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [7:0]           id_reg, id_next;
    logic [TIME_BITS-1:0] t_reg, t_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic [7:0]           cur_id_reg, cur_id_next;
    logic [TIME_BITS-1:0] cur_t_reg, cur_t_next;
    logic [7:0]           lid_reg, lid_next;
    logic [TIME_BITS-1:0] lt_reg, lt_next;
    logic [1:0]           status_reg, status_next;
    logic                 popped_reg, popped_next;
    logic [7:0]           pid_reg, pid_next;
    logic [TIME_BITS-1:0] pt_reg, pt_next;
    logic                 try_down_reg, try_down_next;
    logic                 moved_reg, moved_next;
    logic [ID_COUNT-1:0]  valid_reg, valid_next;
    logic                 m_valid_reg, m_valid_next;
    out_t                 m_data_reg, m_data_next;

    logic [SW-1:0] heap_ra, heap_wa;
    logic [EW-1:0] heap_wd, heap_rd_q;
    logic          heap_we;
    logic [SW-1:0] map_wd, map_rd_q;
    logic [7:0]    map_wa;
    logic          map_we;

    logic [7:0]           q_id;
    logic [TIME_BITS-1:0] q_t;
    logic [LW-1:0]        l_idx, r_idx, cnt_ext;
    logic [SW-1:0]        parent;
    logic                 l_ok, r_ok;

    assign q_id    = heap_rd_q[EW-1:TIME_BITS];
    assign q_t     = heap_rd_q[TIME_BITS-1:0];
    assign l_idx   = {1'b0, slot_reg, 1'b1};
    assign r_idx   = l_idx + LW'(1);
    assign cnt_ext = LW'(cnt_reg);
    assign l_ok    = l_idx < cnt_ext;
    assign r_ok    = r_idx < cnt_ext;
    assign parent  = SW'(slot_reg - SW'(1)) >> 1;

    always_ff @(posedge aclk) begin
        heap_rd_q <= heap_mem[heap_ra];
        if (heap_we) begin
            heap_mem[heap_wa] <= heap_wd;
        end
    end

    always_ff @(posedge aclk) begin
        map_rd_q <= map_mem[id_reg];
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        t_reg        <= t_next;
        slot_reg     <= slot_next;
        cur_id_reg   <= cur_id_next;
        cur_t_reg    <= cur_t_next;
        lid_reg      <= lid_next;
        lt_reg       <= lt_next;
        status_reg   <= status_next;
        popped_reg   <= popped_next;
        pid_reg      <= pid_next;
        pt_reg       <= pt_next;
        try_down_reg <= try_down_next;
        moved_reg    <= moved_next;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        t_next        = t_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        cur_id_next   = cur_id_reg;
        cur_t_next    = cur_t_reg;
        lid_next      = lid_reg;
        lt_next       = lt_reg;
        status_next   = status_reg;
        popped_next   = popped_reg;
        pid_next      = pid_reg;
        pt_next       = pt_reg;
        try_down_next = try_down_reg;
        moved_next    = moved_reg;
        valid_next    = valid_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        heap_ra       = '0;
        heap_we       = 1'b0;
        heap_wa       = slot_reg;
        heap_wd       = {cur_id_reg, cur_t_reg};
        map_we        = 1'b0;
        map_wa        = cur_id_reg;
        map_wd        = slot_reg;
        s_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next    = s_data.command;
                    id_next     = s_data.conn_id;
                    t_next      = TIME_BITS'(s_data.time_value);
                    status_next = ST_OK;
                    popped_next = 1'b0;
                    pid_next    = '0;
                    pt_next     = '0;
                    moved_next  = 1'b0;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_HEAD_RD;
                case (cmd_reg)
                    CMD_INSERT: begin
                        if (cnt_reg >= CW'(CAPACITY)) begin
                            status_next = ST_FULL;
                        end else if (valid_reg[id_reg]) begin
                            status_next = ST_ID_ERR;
                        end else begin
                            cur_id_next         = id_reg;
                            cur_t_next          = t_reg;
                            valid_next[id_reg]  = 1'b1;
                            slot_next           = SW'(cnt_reg);
                            cnt_next            = cnt_reg + CW'(1);
                            try_down_next       = 1'b0;
                            state_next          = S_UP_RD;
                        end
                    end
                    CMD_UPDATE: begin
                        if (!valid_reg[id_reg]) begin
                            status_next = ST_ID_ERR;
                        end else begin
                            state_next = S_MAP_WAIT;
                        end
                    end
                    CMD_POP: begin
                        popped_next = 1'b1;
                        if (cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            heap_ra    = '0;
                            state_next = S_POP_USE;
                        end
                    end
                    CMD_REMOVE: begin
                        if (cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else if (!valid_reg[id_reg]) begin
                            status_next = ST_ID_ERR;
                        end else begin
                            valid_next[id_reg] = 1'b0;
                            cnt_next           = cnt_reg - CW'(1);
                            state_next         = S_MAP_WAIT;
                        end
                    end
                    default: begin
                        if (cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                        end
                    end
                endcase
            end
            S_MAP_WAIT: begin
                slot_next = map_rd_q;
                if (cmd_reg == CMD_UPDATE) begin
                    heap_ra    = map_rd_q;
                    state_next = S_LOAD_USE;
                end else if (CW'(map_rd_q) == cnt_reg) begin
                    state_next = S_HEAD_RD;
                end else begin
                    heap_ra    = SW'(cnt_reg);
                    state_next = S_LOAD_USE;
                end
            end
            S_POP_USE: begin
                pid_next        = q_id;
                pt_next         = q_t;
                valid_next[q_id] = 1'b0;
                cnt_next        = cnt_reg - CW'(1);
                slot_next       = '0;
                if (cnt_reg == CW'(1)) begin
                    state_next = S_HEAD_RD;
                end else begin
                    heap_ra    = SW'(cnt_reg - CW'(1));
                    state_next = S_LOAD_USE;
                end
            end
            S_LOAD_USE: begin
                if (cmd_reg == CMD_UPDATE) begin
                    cur_id_next   = id_reg;
                    cur_t_next    = t_reg;
                    try_down_next = 1'b0;
                    state_next    = (t_reg < q_t) ? S_UP_RD : S_DN_RDL;
                end else begin
                    cur_id_next   = q_id;
                    cur_t_next    = q_t;
                    try_down_next = (cmd_reg == CMD_REMOVE);
                    state_next    = (cmd_reg == CMD_REMOVE) ? S_UP_RD : S_DN_RDL;
                end
            end
            S_UP_RD: begin
                if (slot_reg == '0) begin
                    state_next = (try_down_reg && !moved_reg) ? S_DN_RDL : S_PLACE;
                end else begin
                    heap_ra    = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (cur_t_reg < q_t) begin
                    heap_we    = 1'b1;
                    heap_wd    = heap_rd_q;
                    map_we     = 1'b1;
                    map_wa     = q_id;
                    slot_next  = parent;
                    moved_next = 1'b1;
                    state_next = S_UP_RD;
                end else begin
                    state_next = (try_down_reg && !moved_reg) ? S_DN_RDL : S_PLACE;
                end
            end
            S_DN_RDL: begin
                if (l_ok) begin
                    heap_ra    = l_idx[SW-1:0];
                    state_next = S_DN_RDR;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_DN_RDR: begin
                lid_next   = q_id;
                lt_next    = q_t;
                heap_ra    = r_idx[SW-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (r_ok && (q_t < lt_reg) && (q_t < cur_t_reg)) begin
                    heap_we    = 1'b1;
                    heap_wd    = heap_rd_q;
                    map_we     = 1'b1;
                    map_wa     = q_id;
                    slot_next  = r_idx[SW-1:0];
                    state_next = S_DN_RDL;
                end else if (lt_reg < cur_t_reg) begin
                    heap_we    = 1'b1;
                    heap_wd    = {lid_reg, lt_reg};
                    map_we     = 1'b1;
                    map_wa     = lid_reg;
                    slot_next  = l_idx[SW-1:0];
                    state_next = S_DN_RDL;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                heap_we    = 1'b1;
                map_we     = 1'b1;
                state_next = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                state_next = S_HEAD_USE;
            end
            S_HEAD_USE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.status     = status_reg;
                    m_data_next.head_valid = (cnt_reg != '0);
                    m_data_next.occupancy  = 9'(cnt_reg);
                    if (popped_reg) begin
                        m_data_next.head_id   = pid_reg;
                        m_data_next.head_time = 32'(pt_reg);
                    end else if (cnt_reg != '0) begin
                        m_data_next.head_id   = q_id;
                        m_data_next.head_time = 32'(q_t);
                    end else begin
                        m_data_next.head_id   = '0;
                        m_data_next.head_time = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `IMHTQ_ASSERT(a_count_bound, cnt_reg <= CW'(CAPACITY))
    `IMHTQ_ASSERT(a_flags_match_count, (state_reg == S_IDLE) |-> ($countones(valid_reg) == int'(cnt_reg)))
    `IMHTQ_ASSERT(a_head_matches_occ, m_valid |-> (m_data.head_valid == (m_data.occupancy != '0)))
    `IMHTQ_ASSERT(a_up_not_root, (state_reg == S_UP_CMP) |-> (slot_reg != '0))
    `IMHTQ_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == S_IDLE) && !m_valid_reg)

endmodule
